// File: hw/rtl/lobm_pkg.sv
// Shared types and codes for the limit order book matcher.
// Beat structs, operation and result codes, slot record and controller types.
`default_nettype none

package lobm_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_BUY    = 2'd0;
  localparam logic [1:0] OP_SELL   = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result kinds of an output beat
  localparam logic [1:0] RK_EXEC   = 2'd0;
  localparam logic [1:0] RK_ADDED  = 2'd1;
  localparam logic [1:0] RK_CANCEL = 2'd2;
  localparam logic [1:0] RK_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] ord_id;
    logic [31:0] limit_price;
    logic [31:0] order_quantity;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] resting_id;
    logic [31:0] active_id;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic        is_sell;
    logic        cancel_ok;
    logic [63:0] symbol;
    logic [63:0] stamp;
    logic        last;
  } out_beat_t;

  // One resting order as held in the slot memory
  typedef struct packed {
    logic        sell;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [31:0] owner;
    logic [31:0] arrival;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic fill;
    logic cancel;
    logic add;
    logic reject;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       in_qty_zero;
    logic       op_cancel;
    logic       scan_done;
    logic       found;
    logic       free_found;
    logic       fill_last;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/lobm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/lobm_ctrl.sv
// Sequencer of the order book: accept, scan the book, then emit a result; rescan after a fill that leaves quantity.
// Uses lobm_pkg for state, command and status types.
`default_nettype none

module lobm_ctrl
  import lobm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_op == OP_NONE ||
              (status_i.in_op != OP_CANCEL && status_i.in_qty_zero)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          if (!status_i.op_cancel && status_i.found && !status_i.fill_last) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_start = !(status_i.in_op == OP_NONE ||
                               (status_i.in_op != OP_CANCEL && status_i.in_qty_zero));
        end
      end
      ST_SCAN: begin
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          if (status_i.op_cancel) begin
            cmd_o.cancel = 1'b1;
          end else if (status_i.found) begin
            cmd_o.fill       = 1'b1;
            cmd_o.scan_start = !status_i.fill_last;
          end else if (status_i.free_found) begin
            cmd_o.add = 1'b1;
          end else begin
            cmd_o.reject = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/lobm_datapath.sv
// Order book datapath: slot memory, scan with best-slot tracking, counters
// and the output beat register. Uses lobm_pkg and lobm_ram.
`default_nettype none

module lobm_datapath
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire in_beat_t    in_beat_i,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_beat_t        out_beat_o,
  input  wire cmd_t        cmd_i,
  output status_t          status_o
);

  localparam int IW = $clog2(BOOK_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(BOOK_DEPTH - 1);

  // Current order
  logic [1:0]  op_q;
  logic [31:0] id_q, limit_q, qty_q;
  logic [63:0] sym_q;
  logic        is_sell;

  // Book state
  logic [BOOK_DEPTH-1:0] valid_q;
  logic [31:0]           arr_ctr_q;
  logic [63:0]           evt_ctr_q;

  // Scan pipeline
  logic          scan_act_q, rd_vld_q;
  logic [IW-1:0] scan_cnt_q, rd_idx_q;

  // Best candidate and first free slot
  logic          found_q, free_found_q;
  logic [IW-1:0] best_idx_q, free_idx_q;
  logic [31:0]   best_price_q, best_rem_q, best_owner_q, best_arr_q;

  // Output register
  logic      out_valid_q;
  out_beat_t out_q;

  // Memory ports
  logic          we;
  logic [IW-1:0] waddr;
  slot_t         wdata, rdata;

  assign is_sell = (op_q == OP_SELL);

  lobm_ram #(
    .WIDTH($bits(slot_t)),
    .DEPTH(BOOK_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (scan_cnt_q),
    .rdata_o (rdata)
  );

  // Fill arithmetic
  logic [31:0] fill_qty, new_rem;
  logic        fill_last;
  assign fill_last = (qty_q <= best_rem_q);
  assign fill_qty  = fill_last ? qty_q : best_rem_q;
  assign new_rem   = best_rem_q - fill_qty;

  // Candidate test on the entry read last cycle
  logic        rd_live, cand, better;
  logic [31:0] age_i, age_best;
  always_comb begin
    rd_live  = rd_vld_q && valid_q[rd_idx_q];
    age_i    = arr_ctr_q - rdata.arrival;
    age_best = arr_ctr_q - best_arr_q;
    if (op_q == OP_CANCEL) begin
      cand   = rd_live && (rdata.owner == id_q);
      better = !found_q || (age_i < age_best);
    end else begin
      cand   = rd_live && (rdata.sell != is_sell) &&
               (is_sell ? (rdata.price >= limit_q) : (rdata.price <= limit_q));
      if (!found_q) begin
        better = 1'b1;
      end else if (rdata.price != best_price_q) begin
        better = is_sell ? (rdata.price > best_price_q) : (rdata.price < best_price_q);
      end else begin
        better = (age_i > age_best);
      end
    end
  end

  // Memory write: fill updates the matched slot, add fills a free one
  always_comb begin
    we    = cmd_i.fill || cmd_i.add;
    waddr = cmd_i.add ? free_idx_q : best_idx_q;
    if (cmd_i.add) begin
      wdata = '{sell: is_sell, price: limit_q, remaining: qty_q,
                owner: id_q, arrival: arr_ctr_q};
    end else begin
      wdata = '{sell: !is_sell, price: best_price_q, remaining: new_rem,
                owner: best_owner_q, arrival: best_arr_q};
    end
  end

  logic emit, out_free;
  assign emit     = cmd_i.fill || cmd_i.cancel || cmd_i.add || cmd_i.reject;
  assign out_free = !out_valid_q || !out_stall_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      arr_ctr_q    <= '0;
      evt_ctr_q    <= '0;
      sym_q        <= '0;
      scan_act_q   <= 1'b0;
      scan_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) sym_q <= cfg_wdata_i;

      // Scan issue and read stage
      rd_vld_q <= scan_act_q;
      rd_idx_q <= scan_cnt_q;
      if (cmd_i.scan_start) begin
        scan_act_q   <= 1'b1;
        scan_cnt_q   <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (scan_act_q) begin
          if (scan_cnt_q == LAST_IDX) begin
            scan_act_q <= 1'b0;
          end else begin
            scan_cnt_q <= scan_cnt_q + 1'b1;
          end
        end
        if (cand && better) found_q <= 1'b1;
        if (rd_vld_q && !valid_q[rd_idx_q]) free_found_q <= 1'b1;
      end

      // Slot occupancy
      if (cmd_i.fill && new_rem == 32'd0) valid_q[best_idx_q] <= 1'b0;
      if (cmd_i.cancel && found_q)        valid_q[best_idx_q] <= 1'b0;
      if (cmd_i.add) begin
        valid_q[free_idx_q] <= 1'b1;
        arr_ctr_q           <= arr_ctr_q + 32'd1;
      end

      if (emit) evt_ctr_q <= evt_ctr_q + 64'd1;

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Next result beat
  out_beat_t out_d;
  always_comb begin
    out_d            = '0;
    out_d.stamp      = evt_ctr_q;
    out_d.resting_id = id_q;
    if (cmd_i.fill) begin
      out_d.result_kind    = RK_EXEC;
      out_d.resting_id     = best_owner_q;
      out_d.active_id      = id_q;
      out_d.trade_price    = best_price_q;
      out_d.trade_quantity = fill_qty;
      out_d.last           = fill_last;
    end else if (cmd_i.cancel) begin
      out_d.result_kind = RK_CANCEL;
      out_d.cancel_ok   = found_q;
      out_d.last        = 1'b1;
    end else begin
      out_d.result_kind    = cmd_i.add ? RK_ADDED : RK_REJECT;
      out_d.trade_price    = limit_q;
      out_d.trade_quantity = qty_q;
      out_d.is_sell        = is_sell;
      out_d.symbol         = sym_q;
      out_d.last           = 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_beat_i.operation;
      id_q    <= in_beat_i.ord_id;
      limit_q <= in_beat_i.limit_price;
      qty_q   <= in_beat_i.order_quantity;
    end else if (cmd_i.fill) begin
      qty_q <= qty_q - fill_qty;
    end
    if (!cmd_i.scan_start && cand && better) begin
      best_idx_q   <= rd_idx_q;
      best_price_q <= rdata.price;
      best_rem_q   <= rdata.remaining;
      best_owner_q <= rdata.owner;
      best_arr_q   <= rdata.arrival;
    end
    if (!cmd_i.scan_start && rd_vld_q && !valid_q[rd_idx_q] && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_comb begin
    status_o             = '0;
    status_o.in_op       = in_beat_i.operation;
    status_o.in_qty_zero = (in_beat_i.order_quantity == 32'd0);
    status_o.op_cancel   = (op_q == OP_CANCEL);
    status_o.scan_done   = rd_vld_q && (rd_idx_q == LAST_IDX);
    status_o.found       = found_q;
    status_o.free_found  = free_found_q;
    status_o.fill_last   = fill_last;
    status_o.out_free    = out_free;
  end

`ifndef NO_ASSERTIONS
  // A result is never loaded over a beat that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result beat overwritten");

  // A fill always has a matched slot that is still live
  a_fill_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |-> found_q && valid_q[best_idx_q]) else $error("fill without live slot");

  // An add goes only to a slot that is free
  a_add_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add |-> free_found_q && !valid_q[free_idx_q]) else $error("add to busy slot");

  // Each emitted result advances the event counter by one
  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> evt_ctr_q == $past(evt_ctr_q) + 64'd1) else $error("stamp not advanced");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/limit_order_book_matcher.sv
// Top level of the price-time priority limit order book matcher.
// Joins lobm_ctrl and lobm_datapath; types from lobm_pkg.
`default_nettype none

// One order or cancel is taken at a time. Each pass over the book reads one
// slot per cycle from the slot memory, and a result is then emitted from
// the decide state. A buy or sell rescans the book after every fill that
// leaves quantity, for the next best price and oldest arrival. Operation 3
// and zero-quantity orders are taken without a scan and give no result.
// Results wait in an output register, so a stalled output delays the
// sequencer by the stall. No clearing pass is needed after reset.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_beat_t    in_beat_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_beat_t        out_beat_o
);

  cmd_t    cmd;
  status_t status;

  lobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lobm_datapath #(
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire
